// ----- hw/rtl/ghash_pkg.sv -----
package ghash_pkg;

  // Block and digit geometry
  localparam int BLOCK_W   = 128;
  localparam int HALF_W    = BLOCK_W / 2;
  localparam int DIGIT_W   = 32;
  localparam int STEPS     = BLOCK_W / DIGIT_W;
  localparam int STEP_W    = $clog2(STEPS);
  localparam int BYTES     = BLOCK_W / 8;
  localparam int COUNT_W   = 5;
  localparam int PROD_W    = BLOCK_W + DIGIT_W - 1;
  localparam int OVF_W     = DIGIT_W - 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_HIGH   = 2'd0,
    REG_KEY_LOW    = 2'd1,
    REG_START_HIGH = 2'd2,
    REG_START_LOW  = 2'd3
  } cfg_reg_t;

  // One classified request as it waits in the queue
  typedef struct packed {
    logic [BLOCK_W-1:0] block;
    logic               restart;
    logic               absorb;
  } ghash_item_t;

  // Multiply by x^32 in the reflected GCM field: shift right, fold the
  // shifted-out bits back with x^128 = x^7 + x^2 + x + 1.
  function automatic logic [BLOCK_W-1:0] gf_mul_x32(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] w;
    w = {v[DIGIT_W-1:0], {(BLOCK_W-DIGIT_W){1'b0}}};
    return (v >> DIGIT_W) ^ w ^ (w >> 1) ^ (w >> 2) ^ (w >> 7);
  endfunction

  // Multiply V by a 32-bit digit (first GCM bit in the digit's MSB), reduced.
  function automatic logic [BLOCK_W-1:0] gf_mul_digit(input logic [DIGIT_W-1:0] d,
                                                      input logic [BLOCK_W-1:0] v);
    logic [PROD_W-1:0]  p;
    logic [PROD_W-1:0]  e;
    logic [OVF_W-1:0]   o;
    logic [BLOCK_W-1:0] w;
    p = '0;
    e = {v, {OVF_W{1'b0}}};
    for (int i = 0; i < DIGIT_W; i++) begin
      if (d[DIGIT_W-1-i]) begin
        p = p ^ (e >> i);
      end
    end
    o = p[OVF_W-1:0];
    w = {o, {(BLOCK_W-OVF_W){1'b0}}};
    return p[PROD_W-1:OVF_W] ^ w ^ (w >> 1) ^ (w >> 2) ^ (w >> 7);
  endfunction

endpackage

// ----- hw/rtl/ghash_accumulator.sv -----
// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_ready  | block_high, block_low, byte_count, restart
// out     | out_valid / out_ready| hash_high, hash_low
// cfg     | cfg_en (no wait)     | cfg_index, cfg_data
//
// A request with data runs the accumulator loop in the back end through one
// 32x128 carry-less digit multiplier per cycle; the last digit holds while out_valid waits on out_ready.
// A request with a zero byte count skips the multiply and passes the base value through.
// A two-entry queue lets the input accept while the multiplier is busy and
// while a finished hash waits on out_ready.
// Synchronous reset clears the configuration, the accumulator and all valids.
module ghash_accumulator
  import ghash_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [HALF_W-1:0]      block_high,
  input  logic [HALF_W-1:0]      block_low,
  input  logic [COUNT_W-1:0]     byte_count,
  input  logic                   restart,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [HALF_W-1:0]      hash_high,
  output logic [HALF_W-1:0]      hash_low
);

  logic [HALF_W-1:0]  key_high;
  logic [HALF_W-1:0]  key_low;
  logic [HALF_W-1:0]  start_high;
  logic [HALF_W-1:0]  start_low;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_nonempty;
  ghash_item_t        push_item;
  ghash_item_t        head_item;
  logic [BLOCK_W-1:0] hash;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      start_high <= '0;
      start_low  <= '0;
    end else if (cfg_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_HIGH:   key_high   <= cfg_data;
        REG_KEY_LOW:    key_low    <= cfg_data;
        REG_START_HIGH: start_high <= cfg_data;
        REG_START_LOW:  start_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  ghash_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .block_high (block_high),
    .block_low  (block_low),
    .byte_count (byte_count),
    .restart    (restart),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  ghash_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_item  (push_item),
    .full     (q_full),
    .pop      (q_pop),
    .rd_item  (head_item),
    .nonempty (q_nonempty)
  );

  ghash_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_nonempty),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .key       ({key_high, key_low}),
    .start     ({start_high, start_low}),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash      (hash)
  );

  assign hash_high = hash[BLOCK_W-1:HALF_W];
  assign hash_low  = hash[HALF_W-1:0];

endmodule

// ----- hw/rtl/ghash_front.sv -----
module ghash_front
  import ghash_pkg::*;
(
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [HALF_W-1:0]    block_high,
  input  logic [HALF_W-1:0]    block_low,
  input  logic [COUNT_W-1:0]   byte_count,
  input  logic                 restart,
  input  logic                 q_full,
  output logic                 q_push,
  output ghash_item_t          q_item
);

  logic [COUNT_W-1:0] count_sat;
  logic [BLOCK_W-1:0] keep;

  // Saturate the count and build the byte mask
  always_comb begin
    count_sat = (byte_count > COUNT_W'(BYTES)) ? COUNT_W'(BYTES) : byte_count;
    for (int b = 0; b < BYTES; b++) begin
      keep[BLOCK_W-1-8*b -: 8] = (COUNT_W'(b) < count_sat) ? 8'hff : 8'h00;
    end
  end

  // Classify the request and push it when the queue has room
  assign in_ready        = !q_full;
  assign q_push          = in_valid && !q_full;
  assign q_item.block    = {block_high, block_low} & keep;
  assign q_item.restart  = restart;
  assign q_item.absorb   = (count_sat != '0);

endmodule

// ----- hw/rtl/ghash_queue.sv -----
module ghash_queue
  import ghash_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ghash_item_t wr_item,
  output logic        full,
  input  logic        pop,
  output ghash_item_t rd_item,
  output logic        nonempty
);

  ghash_item_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rd_item  = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

// ----- hw/rtl/ghash_back.sv -----
module ghash_back
  import ghash_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ghash_item_t        q_item,
  output logic               q_pop,
  input  logic [BLOCK_W-1:0] key,
  input  logic [BLOCK_W-1:0] start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BLOCK_W-1:0] hash
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } back_state_t;

  back_state_t        state;
  back_state_t        state_next;
  logic [STEP_W-1:0]  step;
  logic [BLOCK_W-1:0] xreg;
  logic [BLOCK_W-1:0] vreg;
  logic [BLOCK_W-1:0] rreg;
  logic [BLOCK_W-1:0] acc;
  logic               restart_q;
  logic               absorb_q;
  logic [BLOCK_W-1:0] base;
  logic [BLOCK_W-1:0] xw;
  logic [BLOCK_W-1:0] rsum;
  logic [BLOCK_W-1:0] result;
  logic               busy;
  logic               first;
  logic               last;
  logic               fin;
  logic               advance;

  // One 32-bit digit of the multiply per cycle; the last digit holds while out_valid waits on out_ready
  always_comb begin
    busy    = (state == ST_BUSY);
    base    = restart_q ? start : acc;
    first   = (step == '0);
    xw      = first ? (xreg ^ base) : xreg;
    rsum    = rreg ^ gf_mul_digit(xw[BLOCK_W-1 -: DIGIT_W], vreg);
    last    = !absorb_q || (step == STEP_W'(STEPS-1));
    result  = absorb_q ? rsum : base;
    fin     = busy && last && (!out_valid || out_ready);
    advance = busy && !last;
    q_pop   = q_valid && (!busy || fin);
  end

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = q_pop ? ST_BUSY : ST_IDLE;
      ST_BUSY: state_next = (fin && !q_pop) ? ST_IDLE : ST_BUSY;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      state <= state_next;
      if (q_pop || fin) begin
        step <= '0;
      end else if (advance) begin
        step <= step + 1'b1;
      end
      if (fin) begin
        out_valid <= 1'b1;
        acc       <= result;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load a new request or advance the partial product
  always_ff @(posedge clk) begin
    if (q_pop) begin
      xreg      <= q_item.block;
      restart_q <= q_item.restart;
      absorb_q  <= q_item.absorb;
      vreg      <= key;
      rreg      <= '0;
    end else if (advance) begin
      xreg <= xw << DIGIT_W;
      vreg <= gf_mul_x32(vreg);
      rreg <= rsum;
    end
    if (fin) begin
      hash <= result;
    end
  end

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> step == '0)
    else $error("step counter left nonzero while idle");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> busy && step == $past(step) + 1'b1)
    else $error("multiply step lost or repeated");

  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !fin |=> acc == $past(acc))
    else $error("accumulator changed without a finished request");

endmodule

// ----- tb/ghash_checker.sv -----
module ghash_checker
  import ghash_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [HALF_W-1:0]      block_high,
  input  logic [HALF_W-1:0]      block_low,
  input  logic [COUNT_W-1:0]     byte_count,
  input  logic                   restart,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [HALF_W-1:0]      hash_high,
  input  logic [HALF_W-1:0]      hash_low,
  output int                     errors,
  output int                     pending,
  output int                     requests,
  output int                     results
);
  timeunit 1ns;
  timeprecision 1ps;

  // GCM reduction: 0xE1 followed by 120 zero bits
  localparam logic [BLOCK_W-1:0] REDUCE_POLY = {8'he1, {(BLOCK_W-8){1'b0}}};

  typedef struct packed {
    logic [HALF_W-1:0] high;
    logic [HALF_W-1:0] low;
  } digest_t;

  logic [BLOCK_W-1:0] subkey;
  logic [BLOCK_W-1:0] restart_value;
  logic [BLOCK_W-1:0] running_digest;
  digest_t            digest_queue [$];

  // Bit-serial product in the reflected field; GCM bit 0 is the vector MSB
  function automatic logic [BLOCK_W-1:0] gf128_times(input logic [BLOCK_W-1:0] a,
                                                     input logic [BLOCK_W-1:0] b);
    logic [BLOCK_W-1:0] prod;
    logic [BLOCK_W-1:0] walk;
    logic               carry;
    prod = '0;
    walk = b;
    for (int i = 0; i < BLOCK_W; i++) begin
      if (a[BLOCK_W-1-i]) begin
        prod = prod ^ walk;
      end
      carry = walk[0];
      walk  = walk >> 1;
      if (carry) begin
        walk = walk ^ REDUCE_POLY;
      end
    end
    return prod;
  endfunction

  // Fold one request into the digest; a zero count leaves it untouched
  function automatic logic [BLOCK_W-1:0] absorb_block(input logic [BLOCK_W-1:0] acc,
                                                      input logic [BLOCK_W-1:0] data,
                                                      input logic [COUNT_W-1:0] count,
                                                      input logic [BLOCK_W-1:0] key);
    int                 kept;
    logic [BLOCK_W-1:0] mask;
    kept = (count > BYTES) ? BYTES : int'(count);
    if (kept == 0) begin
      return acc;
    end
    mask = ~({BLOCK_W{1'b1}} >> (8 * kept));
    return gf128_times(acc ^ (data & mask), key);
  endfunction

  // Track configuration, predict on each request, compare on each hash
  always @(posedge clk) begin
    digest_t want;
    if (rst) begin
      subkey         = '0;
      restart_value  = '0;
      running_digest = '0;
      digest_queue.delete();
      errors   = 0;
      requests = 0;
      results  = 0;
    end else begin
      if (cfg_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_KEY_HIGH:   subkey[BLOCK_W-1:HALF_W]        = cfg_data;
          REG_KEY_LOW:    subkey[HALF_W-1:0]              = cfg_data;
          REG_START_HIGH: restart_value[BLOCK_W-1:HALF_W] = cfg_data;
          REG_START_LOW:  restart_value[HALF_W-1:0]       = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (restart) begin
          running_digest = restart_value;
        end
        running_digest = absorb_block(running_digest, {block_high, block_low},
                                      byte_count, subkey);
        digest_queue.push_back(running_digest);
        requests++;
      end
      if (out_valid && out_ready) begin
        results++;
        if (digest_queue.size() == 0) begin
          $error("hash with no request outstanding: hash_high=%h hash_low=%h",
                 hash_high, hash_low);
          errors++;
        end else begin
          want = digest_queue.pop_front();
          if (hash_high !== want.high) begin
            $error("hash_high mismatch: expected %h, actual %h", want.high, hash_high);
            errors++;
          end
          if (hash_low !== want.low) begin
            $error("hash_low mismatch: expected %h, actual %h", want.low, hash_low);
            errors++;
          end
        end
      end
    end
    pending = digest_queue.size();
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import ghash_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 88;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_KEY_HIGH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [HALF_W-1:0]      block_high = '0;
  logic [HALF_W-1:0]      block_low = '0;
  logic [COUNT_W-1:0]     byte_count = '0;
  logic                   restart = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [HALF_W-1:0]      hash_high;
  logic [HALF_W-1:0]      hash_low;

  int errors;
  int pending;
  int requests;
  int results;

  int burst_left = 0;
  int zero_items = 0;
  int restart_items = 0;
  int wide_items = 0;
  int phases = 0;

  ghash_accumulator DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .block_high (block_high),
    .block_low  (block_low),
    .byte_count (byte_count),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_high  (hash_high),
    .hash_low   (hash_low)
  );

  ghash_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .block_high (block_high),
    .block_low  (block_low),
    .byte_count (byte_count),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_high  (hash_high),
    .hash_low   (hash_low),
    .errors     (errors),
    .pending    (pending),
    .requests   (requests),
    .results    (results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Write all four registers on consecutive edges, then drop the enable
  task automatic load_config(input logic [63:0] key_hi, input logic [63:0] key_lo,
                             input logic [63:0] init_hi, input logic [63:0] init_lo);
    cfg_reg_t    regs [4] = '{REG_KEY_HIGH, REG_KEY_LOW, REG_START_HIGH, REG_START_LOW};
    logic [63:0] vals [4];
    vals = '{key_hi, key_lo, init_hi, init_lo};
    for (int i = 0; i < 4; i++) begin
      cfg_en    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_en <= 1'b0;
    phases++;
  endtask

  // Offer one request, idling between some bursts, and hold it until accepted
  task automatic offer(input logic [63:0] hi, input logic [63:0] lo,
                       input logic [COUNT_W-1:0] count, input logic rs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    in_valid   <= 1'b1;
    block_high <= hi;
    block_low  <= lo;
    byte_count <= count;
    restart    <= rs;
    if (count == 0) zero_items++;
    if (count > BYTES) wide_items++;
    if (rs) restart_items++;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Random request: mostly full blocks, some partial, zero and oversized counts
  task automatic offer_random();
    int                 roll;
    int                 fill;
    logic [COUNT_W-1:0] count;
    logic [63:0]        hi;
    logic [63:0]        lo;
    roll = $urandom_range(0, 99);
    if (roll < 70) count = COUNT_W'(BYTES);
    else if (roll < 85) count = COUNT_W'($urandom_range(1, BYTES - 1));
    else if (roll < 92) count = '0;
    else count = COUNT_W'($urandom_range(BYTES + 1, 31));
    fill = $urandom_range(0, 99);
    if (fill < 6) begin
      hi = '0;
      lo = '0;
    end else if (fill < 12) begin
      hi = '1;
      lo = '1;
    end else begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
    end
    offer(hi, lo, count, $urandom_range(0, 7) == 0);
  endtask

  // Idle the input and wait for every outstanding hash
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase();
    repeat (RANDOM_PER_PHASE) offer_random();
    drain();
  endtask

  // Stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Random key and start value, directed corners first
    load_config({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
    offer('0, '0, 5'd16, 1'b1);
    offer('1, '1, 5'd16, 1'b0);
    offer('1, '1, 5'd1, 1'b0);
    offer('1, '1, 5'd7, 1'b0);
    offer('1, '1, 5'd8, 1'b0);
    offer('1, '1, 5'd9, 1'b0);
    offer('1, '1, 5'd15, 1'b0);
    offer({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 1'b0);
    offer({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 1'b1);
    offer({$urandom, $urandom}, {$urandom, $urandom}, 5'd17, 1'b0);
    offer({$urandom, $urandom}, {$urandom, $urandom}, 5'd31, 1'b0);
    offer('1, '1, 5'd24, 1'b0);
    offer({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b1);
    offer({$urandom, $urandom}, {$urandom, $urandom}, 5'd12, 1'b1);
    offer('1, '0, 5'd16, 1'b0);
    offer('0, '1, 5'd16, 1'b0);
    offer({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0);
    offer({$urandom, $urandom}, {$urandom, $urandom}, 5'd3, 1'b0);
    offer({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0);
    offer({$urandom, $urandom}, {$urandom, $urandom}, 5'd11, 1'b1);
    random_phase();

    // Multiplicative identity as key, zero start value
    load_config(64'h8000_0000_0000_0000, '0, '0, '0);
    random_phase();

    // All-ones key and start value
    load_config('1, '1, '1, '1);
    random_phase();

    // Zero key: every absorbed block collapses the digest to zero
    load_config('0, '0, {$urandom, $urandom}, {$urandom, $urandom});
    random_phase();

    // Lowest key bit only, all-ones start value
    load_config('0, 64'h1, '1, '1);
    random_phase();

    load_config({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
    random_phase();

    $display("Covered %0d requests and %0d hashes under %0d key settings,", requests,
             results, phases);
    $display("including %0d zero-count, %0d oversized-count and %0d restart requests.",
             zero_items, wide_items, restart_items);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Output stall pattern, with two long hold-offs to back the block up
  initial begin
    int mode;
    int left;
    int holds;
    mode  = 0;
    left  = 0;
    holds = 0;
    do @(posedge clk); while (rst);
    forever begin
      if ((holds == 0 && requests >= 150) || (holds == 1 && requests >= 400)) begin
        holds++;
        out_ready <= 1'b0;
        repeat ($urandom_range(80, 120)) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(10, 60);
        end
        left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Hard stop
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
